// ===== src/c8alu_pkg.sv =====
// Shared types and constants for the 8/16-bit ALU with flags and decimal adjust.
// Holds the operation codes, flag bit positions and the beat structs of both channels.
// No dependencies.
`default_nettype none

package c8alu_pkg;

  localparam int unsigned OP_W    = 5;
  localparam int unsigned WORD_W  = 16;
  localparam int unsigned FLAGS_W = 8;

  // Flag byte bit positions
  localparam int unsigned FLAG_Z_POS = 7;
  localparam int unsigned FLAG_N_POS = 6;
  localparam int unsigned FLAG_H_POS = 5;
  localparam int unsigned FLAG_C_POS = 4;

  // Flags kept by decimal adjust: N and the low nibble
  localparam logic [FLAGS_W-1:0] DAA_KEEP_MASK = 8'h4F;
  localparam logic [7:0]         DAA_HI_LIMIT  = 8'h99;
  localparam logic [3:0]         DAA_LO_LIMIT  = 4'h9;
  localparam logic [3:0]         DAA_FIX_NIB   = 4'h6;
  localparam logic [WORD_W-1:0]  BIT_IDX_MAX   = 16'd7;

  typedef enum logic [OP_W-1:0] {
    OP_AND  = 5'd0,
    OP_OR   = 5'd1,
    OP_XOR  = 5'd2,
    OP_ADD  = 5'd3,
    OP_SUB  = 5'd4,
    OP_ADC  = 5'd5,
    OP_SBC  = 5'd6,
    OP_RLC  = 5'd7,
    OP_RRC  = 5'd8,
    OP_RL   = 5'd9,
    OP_RR   = 5'd10,
    OP_SLA  = 5'd11,
    OP_SRL  = 5'd12,
    OP_SRA  = 5'd13,
    OP_SWAP = 5'd14,
    OP_BIT  = 5'd15,
    OP_SET  = 5'd16,
    OP_RES  = 5'd17,
    OP_DAA  = 5'd18
  } op_t;

  typedef struct packed {
    logic [OP_W-1:0]    operation;
    logic [WORD_W-1:0]  operand_a;
    logic [WORD_W-1:0]  operand_b;
    logic [FLAGS_W-1:0] flags_in;
    logic               word_mode;
  } in_beat_t;

  typedef struct packed {
    logic [WORD_W-1:0]  result;
    logic               zero;
    logic               carry_byte;
    logic               carry_word;
    logic               borrow;
    logic               half_carry_byte;
    logic               half_carry_word;
    logic               half_borrow;
    logic               a_bit_zero;
    logic               a_bit_seven;
    logic [FLAGS_W-1:0] flags_out;
  } out_beat_t;

endpackage

`default_nettype wire

// ===== src/c8alu_in_if.sv =====
// Input channel of the ALU: valid/ready handshake plus one operation beat.
// Depends on c8alu_pkg for field widths.
`default_nettype none

interface c8alu_in_if
  import c8alu_pkg::*;
();
  logic               valid;
  logic               ready;
  logic [OP_W-1:0]    operation;
  logic [WORD_W-1:0]  operand_a;
  logic [WORD_W-1:0]  operand_b;
  logic [FLAGS_W-1:0] flags_in;
  logic               word_mode;

  modport source (
    output valid, operation, operand_a, operand_b, flags_in, word_mode,
    input  ready
  );
  modport sink (
    input  valid, operation, operand_a, operand_b, flags_in, word_mode,
    output ready
  );
endinterface

`default_nettype wire

// ===== src/c8alu_out_if.sv =====
// Result channel of the ALU: valid/ready handshake plus result and condition bits.
// Depends on c8alu_pkg for field widths.
`default_nettype none

interface c8alu_out_if
  import c8alu_pkg::*;
();
  logic               valid;
  logic               ready;
  logic [WORD_W-1:0]  result;
  logic               zero;
  logic               carry_byte;
  logic               carry_word;
  logic               borrow;
  logic               half_carry_byte;
  logic               half_carry_word;
  logic               half_borrow;
  logic               a_bit_zero;
  logic               a_bit_seven;
  logic [FLAGS_W-1:0] flags_out;

  modport source (
    output valid, result, zero, carry_byte, carry_word, borrow, half_carry_byte,
           half_carry_word, half_borrow, a_bit_zero, a_bit_seven, flags_out,
    input  ready
  );
  modport sink (
    input  valid, result, zero, carry_byte, carry_word, borrow, half_carry_byte,
           half_carry_word, half_borrow, a_bit_zero, a_bit_seven, flags_out,
    output ready
  );
endinterface

`default_nettype wire

// ===== src/cpu8_alu_with_flags_and_daa_core.sv =====
// Top level of the 8/16-bit ALU with raw condition outputs and decimal adjust.
// Depends on c8alu_pkg, c8alu_in_if and c8alu_out_if.
`default_nettype none

// Two-stage ALU: an input register captures each operation beat, one pass of
// combinational logic (a 18-bit add/subtract, logic ops, byte shifts, bit
// ops, decimal adjust) computes the result and raw conditions, and a result
// register presents them on the output channel. Throughput is one operation
// per cycle, set by the single-pass ALU between the two registers, while the
// result side does not stall. Both stages advance together when the result
// register is free or being drained, so a new beat is taken while a finished
// result is still waiting. There is no state across beats, no configuration.
// Outside DAA, zero, carries and borrow come from the unwrapped result and
// the half conditions from operands A and B (carry in counts only for ADC and
// SBC, not for the word half carry). BIT, SET and RES with an index above
// seven give 0. DAA sets only zero and carry_byte and puts the adjusted flag
// byte on flags_out; others echo flags_in there. Unused codes give result 0.
module cpu8_alu_with_flags_and_daa_core
  import c8alu_pkg::*;
(
  input  wire logic   clk,
  input  wire logic   rst_n,
  c8alu_in_if.sink    in_chan,
  c8alu_out_if.source out_chan
);

  // Pipeline registers
  in_beat_t  in_r;
  logic      in_vld_r;
  out_beat_t out_r;
  logic      out_vld_r;

  logic      out_adv;   // result register can load
  logic      in_adv;    // input register can load

  // Advance the result stage when empty or drained this cycle
  assign out_adv       = !out_vld_r || out_chan.ready;
  assign in_adv        = !in_vld_r || out_adv;
  assign in_chan.ready = in_adv;

  // ---------------------------------------------------------------------
  // ALU datapath
  // ---------------------------------------------------------------------
  logic [WORD_W-1:0]  a;
  logic [WORD_W-1:0]  b;
  logic [7:0]         a8;
  logic [FLAGS_W-1:0] flg;
  logic               cin;
  logic               cuse;
  logic [WORD_W+1:0]  r;       // unwrapped result, two's complement
  logic [WORD_W+1:0]  sum;
  logic [WORD_W+1:0]  diff;
  logic               bit_ok;
  logic [WORD_W-1:0]  bmask;
  logic [4:0]         hsum;
  logic [12:0]        hsum_w;
  logic [4:0]         hdiff;
  logic               neg;
  op_t                op;

  // Decimal adjust
  logic               d_n;
  logic               d_h;
  logic               d_c;
  logic               fix_lo;
  logic               fix_hi;
  logic [7:0]         fix;
  logic [7:0]         dv;

  out_beat_t          res_nxt;

  always_comb begin
    a    = in_r.operand_a;
    b    = in_r.operand_b;
    a8   = a[7:0];
    flg  = in_r.flags_in;
    cin  = flg[FLAG_C_POS];
    op   = op_t'(in_r.operation);
    cuse = (op == OP_ADC) || (op == OP_SBC) ? cin : 1'b0;

    sum  = {2'b00, a} + {2'b00, b} + {{(WORD_W+1){1'b0}}, cuse};
    diff = {2'b00, a} - {2'b00, b} - {{(WORD_W+1){1'b0}}, cuse};

    // Bit index is operand A; anything above seven yields zero
    bit_ok = (a <= BIT_IDX_MAX);
    bmask  = WORD_W'(1) << a[2:0];

    unique case (op)
      OP_AND:  r = {2'b00, a & b};
      OP_OR:   r = {2'b00, a | b};
      OP_XOR:  r = {2'b00, a ^ b};
      OP_ADD:  r = sum;
      OP_SUB:  r = diff;
      OP_ADC:  r = sum;
      OP_SBC:  r = diff;
      OP_RLC:  r = {10'd0, a8[6:0], a8[7]};
      OP_RRC:  r = {10'd0, a8[0], a8[7:1]};
      OP_RL:   r = {10'd0, a8[6:0], cin};
      OP_RR:   r = {10'd0, cin, a8[7:1]};
      OP_SLA:  r = {10'd0, a8[6:0], 1'b0};
      OP_SRL:  r = {10'd0, 1'b0, a8[7:1]};
      OP_SRA:  r = {10'd0, a8[7], a8[7:1]};
      OP_SWAP: r = {10'd0, a8[3:0], a8[7:4]};
      OP_BIT:  r = bit_ok ? {2'b00, b & bmask}  : '0;
      OP_SET:  r = bit_ok ? {2'b00, b | bmask}  : '0;
      OP_RES:  r = bit_ok ? {2'b00, b & ~bmask} : '0;
      default: r = '0;
    endcase

    neg    = r[WORD_W+1];
    hsum   = {1'b0, a[3:0]} + {1'b0, b[3:0]} + {4'd0, cuse};
    hsum_w = {1'b0, a[11:0]} + {1'b0, b[11:0]};
    hdiff  = {1'b0, a[3:0]} - {1'b0, b[3:0]} - {4'd0, cuse};

    // Decimal adjust of the accumulator byte
    d_n    = flg[FLAG_N_POS];
    d_h    = flg[FLAG_H_POS];
    d_c    = flg[FLAG_C_POS];
    fix_lo = d_h || (!d_n && (a8[3:0] > DAA_LO_LIMIT));
    fix_hi = d_c || (!d_n && (a8 > DAA_HI_LIMIT));
    fix    = {fix_hi ? DAA_FIX_NIB : 4'h0, fix_lo ? DAA_FIX_NIB : 4'h0};
    dv     = d_n ? (a8 - fix) : (a8 + fix);

    if (op == OP_DAA) begin
      res_nxt                 = '0;
      res_nxt.result          = {8'd0, dv};
      res_nxt.zero            = (dv == 8'd0);
      res_nxt.carry_byte      = fix_hi;
      res_nxt.flags_out       = flg & DAA_KEEP_MASK;
      res_nxt.flags_out[FLAG_C_POS] = fix_hi;
      res_nxt.flags_out[FLAG_Z_POS] = (dv == 8'd0);
    end else begin
      res_nxt.result          = r[WORD_W-1:0];
      res_nxt.zero            = in_r.word_mode ? (r == '0) : (r[7:0] == 8'd0);
      res_nxt.carry_byte      = !neg && (|r[WORD_W:8]);
      res_nxt.carry_word      = !neg && r[WORD_W];
      res_nxt.borrow          = neg;
      res_nxt.half_carry_byte = hsum[4];
      res_nxt.half_carry_word = hsum_w[12];
      res_nxt.half_borrow     = hdiff[4];
      res_nxt.a_bit_zero      = a[0];
      res_nxt.a_bit_seven     = a[7];
      res_nxt.flags_out       = flg;
    end
  end

  // ---------------------------------------------------------------------
  // Stage registers: hold on stall, advance both stages together
  // ---------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r  <= 1'b0;
      out_vld_r <= 1'b0;
    end else begin
      if (in_adv) begin
        in_vld_r <= in_chan.valid;
      end
      if (out_adv) begin
        out_vld_r <= in_vld_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_adv && in_chan.valid) begin
      in_r.operation <= in_chan.operation;
      in_r.operand_a <= in_chan.operand_a;
      in_r.operand_b <= in_chan.operand_b;
      in_r.flags_in  <= in_chan.flags_in;
      in_r.word_mode <= in_chan.word_mode;
    end
    if (out_adv && in_vld_r) begin
      out_r <= res_nxt;
    end
  end

  // Drive the result channel
  assign out_chan.valid           = out_vld_r;
  assign out_chan.result          = out_r.result;
  assign out_chan.zero            = out_r.zero;
  assign out_chan.carry_byte      = out_r.carry_byte;
  assign out_chan.carry_word      = out_r.carry_word;
  assign out_chan.borrow          = out_r.borrow;
  assign out_chan.half_carry_byte = out_r.half_carry_byte;
  assign out_chan.half_carry_word = out_r.half_carry_word;
  assign out_chan.half_borrow     = out_r.half_borrow;
  assign out_chan.a_bit_zero      = out_r.a_bit_zero;
  assign out_chan.a_bit_seven     = out_r.a_bit_seven;
  assign out_chan.flags_out       = out_r.flags_out;

endmodule

`default_nettype wire

// ===== tb/sv/alu_result_checker.sv =====
// Result checker for the 8/16-bit ALU: watches both channels, computes each result and compares.
// Depends on c8alu_pkg, c8alu_in_if and c8alu_out_if.
module alu_result_checker
  import c8alu_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst_n,
  c8alu_in_if       in_mon,
  c8alu_out_if      out_mon,
  output int        error_count,
  output int        results_outstanding
);
  timeunit 1ns;
  timeprecision 1ps;

  out_beat_t alu_results_due[$];

  function automatic out_beat_t compute_alu_result(input in_beat_t op_beat);
    out_beat_t  res;
    int         a, b, r, cin, cuse;
    logic [7:0] low_a, shifted, flg, fix, acc, adj;
    logic [15:0] mask, changed;
    logic       neg, dcy;
    res   = '0;
    a     = op_beat.operand_a;
    b     = op_beat.operand_b;
    flg   = op_beat.flags_in;
    cin   = flg[FLAG_C_POS];
    cuse  = 0;
    r     = 0;
    low_a = op_beat.operand_a[7:0];
    if (op_beat.operation == OP_DAA) begin
      acc = low_a;
      neg = flg[FLAG_N_POS];
      fix = '0;
      dcy = 1'b0;
      if (flg[FLAG_H_POS] || (!neg && acc[3:0] > DAA_LO_LIMIT)) fix[3:0] = DAA_FIX_NIB;
      if (flg[FLAG_C_POS] || (!neg && acc > DAA_HI_LIMIT)) begin
        fix[7:4] = DAA_FIX_NIB;
        dcy = 1'b1;
      end
      adj = neg ? acc - fix : acc + fix;
      res.result     = {8'h00, adj};
      res.zero       = (adj == 8'h00);
      res.carry_byte = dcy;
      res.flags_out  = flg & DAA_KEEP_MASK;
      res.flags_out[FLAG_C_POS] = dcy;
      res.flags_out[FLAG_Z_POS] = (adj == 8'h00);
      return res;
    end
    case (op_beat.operation)
      OP_AND:  r = a & b;
      OP_OR:   r = a | b;
      OP_XOR:  r = a ^ b;
      OP_ADD:  r = a + b;
      OP_SUB:  r = a - b;
      OP_ADC: begin
        cuse = cin;
        r = a + b + cin;
      end
      OP_SBC: begin
        cuse = cin;
        r = a - b - cin;
      end
      OP_RLC, OP_RRC, OP_RL, OP_RR, OP_SLA, OP_SRL, OP_SRA, OP_SWAP: begin
        case (op_beat.operation)
          OP_RLC:  shifted = {low_a[6:0], low_a[7]};
          OP_RRC:  shifted = {low_a[0], low_a[7:1]};
          OP_RL:   shifted = {low_a[6:0], flg[FLAG_C_POS]};
          OP_RR:   shifted = {flg[FLAG_C_POS], low_a[7:1]};
          OP_SLA:  shifted = {low_a[6:0], 1'b0};
          OP_SRL:  shifted = {1'b0, low_a[7:1]};
          OP_SRA:  shifted = {low_a[7], low_a[7:1]};
          default: shifted = {low_a[3:0], low_a[7:4]};
        endcase
        r = shifted;
      end
      OP_BIT, OP_SET, OP_RES: begin
        // index past bit seven wipes the result
        if (op_beat.operand_a <= BIT_IDX_MAX) begin
          mask = 16'd1 << op_beat.operand_a[2:0];
          if (op_beat.operation == OP_BIT)      changed = op_beat.operand_b & mask;
          else if (op_beat.operation == OP_SET) changed = op_beat.operand_b | mask;
          else                                  changed = op_beat.operand_b & ~mask;
          r = changed;
        end
      end
      default: r = 0;
    endcase
    res.result          = r[15:0];
    res.zero            = op_beat.word_mode ? (r == 0) : (r[7:0] == 8'h00);
    res.carry_byte      = r > 255;
    res.carry_word      = r > 65535;
    res.borrow          = r < 0;
    res.half_carry_byte = (((a & 15) + (b & 15) + cuse) & 16) != 0;
    res.half_carry_word = (((a & 4095) + (b & 4095)) & 4096) != 0;
    res.half_borrow     = ((a & 15) - (b & 15) - cuse) < 0;
    res.a_bit_zero      = op_beat.operand_a[0];
    res.a_bit_seven     = op_beat.operand_a[7];
    res.flags_out       = flg;
    return res;
  endfunction

  task automatic check_field(input string field, input logic [15:0] want,
                             input logic [15:0] got);
    if (got !== want) begin
      $error("%s mismatch: expected %0h, got %0h", field, want, got);
      error_count++;
    end
  endtask

  always @(posedge clk) begin
    in_beat_t  op_seen;
    out_beat_t due;
    if (rst_n) begin
      if (in_mon.valid && in_mon.ready) begin
        op_seen.operation = in_mon.operation;
        op_seen.operand_a = in_mon.operand_a;
        op_seen.operand_b = in_mon.operand_b;
        op_seen.flags_in  = in_mon.flags_in;
        op_seen.word_mode = in_mon.word_mode;
        alu_results_due.push_back(compute_alu_result(op_seen));
      end
      if (out_mon.valid && out_mon.ready) begin
        if (alu_results_due.size() == 0) begin
          $error("result beat with no operation outstanding");
          error_count++;
        end else begin
          due = alu_results_due.pop_front();
          check_field("result", due.result, out_mon.result);
          check_field("zero", due.zero, out_mon.zero);
          check_field("carry_byte", due.carry_byte, out_mon.carry_byte);
          check_field("carry_word", due.carry_word, out_mon.carry_word);
          check_field("borrow", due.borrow, out_mon.borrow);
          check_field("half_carry_byte", due.half_carry_byte, out_mon.half_carry_byte);
          check_field("half_carry_word", due.half_carry_word, out_mon.half_carry_word);
          check_field("half_borrow", due.half_borrow, out_mon.half_borrow);
          check_field("a_bit_zero", due.a_bit_zero, out_mon.a_bit_zero);
          check_field("a_bit_seven", due.a_bit_seven, out_mon.a_bit_seven);
          check_field("flags_out", due.flags_out, out_mon.flags_out);
        end
      end
    end
    results_outstanding <= alu_results_due.size();
  end

endmodule

// ===== tb/sv/testbench.sv =====
// Top of the ALU testbench: clock, reset, operation stimulus, result-side stalls and verdict.
// Depends on c8alu_pkg, both channel interfaces, alu_result_checker and the ALU core.
module testbench;
  import c8alu_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int RANDOM_OPS = 1520;
  localparam int LONG_HOLD  = 300;
  localparam int RUN_LIMIT  = 600000;
  localparam int SETTLE     = 8;
  // highest code the operation field can carry; everything past DAA is unused
  localparam logic [OP_W-1:0] OP_LAST_CODE = '1;

  logic clk;
  logic rst_n;
  int   error_count;
  int   results_outstanding;
  int   cycles;

  // Shared knobs: calm stops idling on both sides, hold_req asks the result
  // side for one long stall.
  bit calm;
  bit hold_req;
  bit hold_done;

  c8alu_in_if  in_chan();
  c8alu_out_if out_chan();

  cpu8_alu_with_flags_and_daa_core u_top (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_chan),
    .out_chan (out_chan)
  );

  alu_result_checker u_checker (
    .clk                 (clk),
    .rst_n               (rst_n),
    .in_mon              (in_chan),
    .out_mon             (out_chan),
    .error_count         (error_count),
    .results_outstanding (results_outstanding)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // Guard against a hung handshake: give up well past the slowest legal run.
  initial begin
    for (cycles = 0; cycles < RUN_LIMIT; cycles++) @(posedge clk);
    $display("TB_ERROR");
    $finish;
  end

  // Mostly short gaps before a beat, now and then a long one.
  function automatic int idle_cycles();
    int roll;
    if (calm) return 0;
    roll = $urandom_range(0, 99);
    if (roll < 60) return 0;
    if (roll < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  // Bias operands toward the edges where carries and zero tests flip.
  function automatic logic [15:0] pick_operand();
    case ($urandom_range(0, 7))
      0: return '0;
      1: return '1;
      2: return 16'($urandom_range(0, 255));
      3: return 16'($urandom_range(0, 15)) << (4 * $urandom_range(0, 3));
      default: return 16'($urandom);
    endcase
  endfunction

  // Offer one operation beat and hold it until the block takes it. Valid is
  // dropped only when a gap follows, so it never toggles within one step.
  task automatic send_op(input logic [OP_W-1:0] op, input logic [15:0] a,
                         input logic [15:0] b, input logic [7:0] flags,
                         input logic word);
    int gap;
    gap = idle_cycles();
    if (gap > 0) begin
      in_chan.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_chan.valid     <= 1'b1;
    in_chan.operation <= op;
    in_chan.operand_a <= a;
    in_chan.operand_b <= b;
    in_chan.flags_in  <= flags;
    in_chan.word_mode <= word;
    do @(posedge clk); while (in_chan.ready !== 1'b1);
  endtask

  // Stop offering until every computed result has come back.
  task automatic wait_drained();
    in_chan.valid <= 1'b0;
    do @(posedge clk); while (results_outstanding != 0);
  endtask

  task automatic send_random_op();
    logic [OP_W-1:0] op;
    logic [15:0]     a, b;
    logic [7:0]      flags, x, y;
    logic [8:0]      sum;
    logic            word;
    if ($urandom_range(0, 99) < 5) op = OP_W'($urandom_range(OP_DAA + 1, OP_LAST_CODE));
    else                           op = OP_W'($urandom_range(OP_AND, OP_DAA));
    a     = pick_operand();
    b     = pick_operand();
    flags = 8'($urandom);
    word  = 1'($urandom);
    // keep most bit indexes in range so set/res really touch a bit
    if ((op == OP_BIT || op == OP_SET || op == OP_RES) && $urandom_range(0, 9) < 8)
      a = 16'($urandom_range(0, BIT_IDX_MAX));
    // a third of DAA beats follow a real BCD add or subtract with its flags
    if (op == OP_DAA && $urandom_range(0, 2) == 0) begin
      x = {4'($urandom_range(0, 9)), 4'($urandom_range(0, 9))};
      y = {4'($urandom_range(0, 9)), 4'($urandom_range(0, 9))};
      if ($urandom_range(0, 1) == 1) begin
        sum = x + y;
        flags[FLAG_N_POS] = 1'b0;
        flags[FLAG_H_POS] = (x[3:0] + y[3:0]) > 5'd15;
        flags[FLAG_C_POS] = sum[8];
      end else begin
        sum = x - y;
        flags[FLAG_N_POS] = 1'b1;
        flags[FLAG_H_POS] = x[3:0] < y[3:0];
        flags[FLAG_C_POS] = x < y;
      end
      a[7:0] = sum[7:0];
    end
    send_op(op, a, b, flags, word);
  endtask

  // Result side: random ready with short and long stalls, a calm mode with
  // ready held high, and one long hold-off on request.
  initial begin
    int span;
    out_chan.ready <= 1'b0;
    wait (rst_n === 1'b1);
    @(posedge clk);
    forever begin
      if (hold_req && !hold_done) begin
        out_chan.ready <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk);
        hold_done = 1'b1;
      end else if (calm) begin
        out_chan.ready <= 1'b1;
        @(posedge clk);
      end else if ($urandom_range(0, 3) != 0) begin
        out_chan.ready <= 1'b1;
        repeat ($urandom_range(1, 12)) @(posedge clk);
      end else begin
        span = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40) : $urandom_range(1, 3);
        out_chan.ready <= 1'b0;
        repeat (span) @(posedge clk);
      end
    end
  end

  initial begin
    // drive every input to a known value before the first edge
    rst_n              <= 1'b0;
    in_chan.valid      <= 1'b0;
    in_chan.operation  <= OP_AND;
    in_chan.operand_a  <= '0;
    in_chan.operand_b  <= '0;
    in_chan.flags_in   <= '0;
    in_chan.word_mode  <= 1'b0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: field extremes, each operation and the corner cases.
    send_op(OP_AND,  16'hFFFF, 16'hFFFF, 8'h00, 1'b1);
    send_op(OP_OR,   16'h0000, 16'h0000, 8'hFF, 1'b1);  // word-mode zero
    send_op(OP_XOR,  16'h00FF, 16'h00FF, 8'h00, 1'b0);
    send_op(OP_ADD,  16'hFFFF, 16'hFFFF, 8'h00, 1'b1);  // carries out of both widths
    send_op(OP_ADD,  16'h000F, 16'h0001, 8'h00, 1'b0);  // half carry only
    send_op(OP_ADD,  16'h0080, 16'h0080, 8'h00, 1'b0);  // low byte wraps to zero
    send_op(OP_SUB,  16'h0000, 16'h0001, 8'h00, 1'b0);  // borrow and half borrow
    send_op(OP_SUB,  16'h1234, 16'h1234, 8'h00, 1'b1);
    send_op(OP_ADC,  16'h000F, 16'h0000, 8'h10, 1'b0);  // carry in alone makes half carry
    send_op(OP_ADC,  16'hFFFF, 16'hFFFF, 8'hFF, 1'b1);
    send_op(OP_SBC,  16'h0000, 16'h0000, 8'h10, 1'b0);  // carry in alone makes borrow
    send_op(OP_SBC,  16'h0010, 16'h000F, 8'h00, 1'b0);
    send_op(OP_RLC,  16'h0080, 16'h0000, 8'h00, 1'b0);
    send_op(OP_RRC,  16'h0001, 16'h0000, 8'h00, 1'b0);
    send_op(OP_RL,   16'h0080, 16'h0000, 8'h10, 1'b0);
    send_op(OP_RR,   16'h0001, 16'h0000, 8'h10, 1'b0);
    send_op(OP_SLA,  16'hFF80, 16'hFFFF, 8'h00, 1'b1);  // upper byte ignored by shifts
    send_op(OP_SRL,  16'h0001, 16'h0000, 8'h00, 1'b0);
    send_op(OP_SRA,  16'h0080, 16'h0000, 8'h00, 1'b0);
    send_op(OP_SWAP, 16'h00F0, 16'h0000, 8'h00, 1'b0);
    send_op(OP_BIT,  16'h0007, 16'h0080, 8'h00, 1'b0);
    send_op(OP_BIT,  16'h0008, 16'hFFFF, 8'h00, 1'b0);  // index past seven
    send_op(OP_SET,  16'hFFFF, 16'h0000, 8'h00, 1'b1);  // index past seven
    send_op(OP_RES,  16'h0007, 16'h00FF, 8'h00, 1'b0);
    send_op(OP_DAA,  16'h009A, 16'h0000, 8'h00, 1'b0);  // adjusts to zero with carry
    send_op(OP_DAA,  16'h000F, 16'h0000, 8'h60, 1'b0);  // subtract form with half borrow
    send_op(OP_DAA,  16'h0000, 16'h0000, 8'hBF, 1'b0);  // carry in, low nibble kept
    send_op(OP_LAST_CODE, 16'hFFFF, 16'hFFFF, 8'hFF, 1'b1);
    wait_drained();

    // Random: one long result-side stall with the sender pushing back to
    // back, a calm stretch, and a full drain in the middle.
    for (int i = 0; i < RANDOM_OPS; i++) begin
      if (i == 200) begin
        hold_req = 1'b1;
        calm     = 1'b1;
      end
      if (i == 260 || i == 900) calm = 1'b0;
      if (i == 800) calm = 1'b1;
      if (i == 1000) wait_drained();
      send_random_op();
    end

    wait_drained();
    repeat (SETTLE) @(posedge clk);
    if (error_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
